### design/aac_fr_pkg.sv
package aac_fr_pkg;

	localparam logic [2:0]  HDR_LEN     = 3'd7;
	localparam logic [12:0] MAX_PAYLOAD = 13'd8184;
	localparam logic [7:0]  SYNC_HI     = 8'hFF;
	localparam logic [7:0]  SYNC_LO     = 8'hF1;
	localparam logic [7:0]  HDR_TAIL    = 8'hFC;
	localparam logic [10:0] FULLNESS    = 11'h7FF;
	localparam int          CFG_DATA_W  = 5;

	typedef enum logic [1:0] {
		CFG_OBJECT_TYPE       = 2'd0,
		CFG_SAMPLE_RATE_INDEX = 2'd1,
		CFG_CHANNEL_SETUP     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0] object_type;
		logic [3:0] sample_rate_index;
		logic [3:0] channel_setup;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        frame_start;
		logic [12:0] frame_bytes;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	// staged word between the frame tracker and the emitter
	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		logic        start;
		logic [12:0] total;
		logic        frame_end;
	} stage_t;

	function automatic logic [7:0] hdr_byte(cfg_t cfg, logic [12:0] total, logic [2:0] idx);
		logic [1:0] profile;
		logic [2:0] ch;
		logic [7:0] b;
		profile = cfg.object_type[1:0] + 2'd3;
		ch = cfg.channel_setup[2:0];
		case (idx)
			3'd0: b = SYNC_HI;
			3'd1: b = SYNC_LO;
			3'd2: b = {profile, cfg.sample_rate_index, 1'b0, ch[2]};
			3'd3: b = {ch[1:0], 4'b0000, total[12:11]};
			3'd4: b = total[10:3];
			3'd5: b = {total[2:0], FULLNESS[10:6]};
			3'd6: b = HDR_TAIL;
			default: b = HDR_TAIL;
		endcase
		return b;
	endfunction

endpackage

### design/aac_adts_header_framer_core.sv
// ADTS header framer.
// item channel (valid/ready): one raw AAC byte per word; frame_start marks the
// first byte of a frame and frame_bytes then gives the payload length.
// result channel (valid/ready): the ADTS stream, one byte per word, flagged
// is_header for the seven inserted header bytes, frame_end on the last
// payload byte and run_last on the last word caused by an input word.
// cfg port: write enable, index and data; the user must see that it is
// written only while idle, which the block itself does not enforce. A word
// is registered in the stage register when accepted, its first result then
// in the result register. Continuation bytes pass at one per cycle while
// result_ready is high. A start word holds the stage register, stalling the
// input, while seven header bytes from a 3-bit header counter and then the
// byte itself go out. Words outside an open frame are dropped.
// Reset clears the open-frame counter and both valid flags and loads the
// default configuration (object type 2, rate index 4, channel setup 2).
// When the receiver stalls the result register holds; the stage register
// still takes one word, and item_ready drops once both are full.
module aac_adts_header_framer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  aac_fr_pkg::in_item_t                  item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output aac_fr_pkg::out_item_t                 result,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [aac_fr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	aac_fr_pkg::cfg_t   cfg_q;
	aac_fr_pkg::stage_t stage;
	logic               stage_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.object_type <= 5'd2;
			cfg_q.sample_rate_index <= 4'd4;
			cfg_q.channel_setup <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				aac_fr_pkg::CFG_OBJECT_TYPE: begin
					cfg_q.object_type <= cfg_data;
				end
				aac_fr_pkg::CFG_SAMPLE_RATE_INDEX: begin
					cfg_q.sample_rate_index <= cfg_data[3:0];
				end
				aac_fr_pkg::CFG_CHANNEL_SETUP: begin
					cfg_q.channel_setup <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	aac_fr_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.stage      (stage),
		.stage_done (stage_done)
	);

	aac_fr_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.stage        (stage),
		.stage_done   (stage_done),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### design/aac_fr_track.sv
module aac_fr_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  aac_fr_pkg::in_item_t item,
	output logic                 item_ready,
	output aac_fr_pkg::stage_t   stage,
	input  logic                 stage_done
);

	logic [12:0] bytes_left_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [12:0] total_s1;
	logic        fend_s1;

	logic        acc;
	logic        keep;
	logic [12:0] n;
	logic [12:0] next_left;

	assign item_ready = !valid_s1 || stage_done;
	assign acc = item_valid && item_ready;

	always_comb begin
		if (item.frame_bytes == 13'd0) begin
			n = 13'd1;
		end else if (item.frame_bytes > aac_fr_pkg::MAX_PAYLOAD) begin
			n = aac_fr_pkg::MAX_PAYLOAD;
		end else begin
			n = item.frame_bytes;
		end
		// a continuation word with no open frame is dropped
		keep = item.frame_start || (bytes_left_q != 13'd0);
		next_left = item.frame_start ? (n - 13'd1) : (bytes_left_q - 13'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 13'd0;
			valid_s1 <= 1'b0;
		end else if (acc) begin
			if (keep) begin
				bytes_left_q <= next_left;
			end
			valid_s1 <= keep;
		end else if (stage_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_s1 <= item.payload_byte;
			start_s1 <= item.frame_start;
			total_s1 <= n + {10'd0, aac_fr_pkg::HDR_LEN};
			fend_s1 <= (next_left == 13'd0);
		end
	end

	assign stage = '{valid: valid_s1, payload_byte: byte_s1, start: start_s1,
		total: total_s1, frame_end: fend_s1};

	a_fend_closes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fend_s1 |-> bytes_left_q == 13'd0)
		else $error("staged frame end with bytes still open");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !item.frame_start && bytes_left_q == 13'd0 |=> !valid_s1)
		else $error("word outside a frame was staged");

endmodule

### design/aac_fr_emit.sv
module aac_fr_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aac_fr_pkg::cfg_t      cfg,
	input  aac_fr_pkg::stage_t    stage,
	output logic                  stage_done,
	output logic                  result_valid,
	input  logic                  result_ready,
	output aac_fr_pkg::out_item_t result
);

	logic [2:0]            idx_q;
	logic                  res_valid_q;
	aac_fr_pkg::out_item_t res_q;

	logic load;
	logic emit;
	logic hdr_phase;

	assign load = !res_valid_q || result_ready;
	assign emit = stage.valid && load;
	// start words send seven header bytes before their own byte
	assign hdr_phase = stage.start && (idx_q != aac_fr_pkg::HDR_LEN);
	assign stage_done = emit && !hdr_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= hdr_phase ? (idx_q + 3'd1) : 3'd0;
			end
			if (load) begin
				res_valid_q <= stage.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_byte <= hdr_phase ?
				aac_fr_pkg::hdr_byte(cfg, stage.total, idx_q) : stage.payload_byte;
			res_q.is_header <= hdr_phase;
			res_q.frame_end <= !hdr_phase && stage.frame_end;
			res_q.run_last <= !hdr_phase;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	a_hdr_holds: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> stage.valid && stage.start)
		else $error("header sequence running without a start word");

	a_done_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		stage_done |-> !stage.start || idx_q == aac_fr_pkg::HDR_LEN)
		else $error("start word released before its header");

endmodule

### tb/tb_aac_adts_header_framer_core.sv
`timescale 1ns / 100ps

module tb_aac_adts_header_framer_core;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int PHASE_WORDS  = 28;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	aac_fr_pkg::in_item_t  item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	aac_fr_pkg::out_item_t result;
	logic                  cfg_we = 1'b0;
	aac_fr_pkg::cfg_idx_t  cfg_index = aac_fr_pkg::CFG_OBJECT_TYPE;
	logic [aac_fr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	aac_adts_header_framer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	aac_fr_pkg::in_item_t  pending_words[$];
	aac_fr_pkg::out_item_t adts_bytes_due[$];

	// shadow of the block's settings and open-frame counter
	logic [4:0]  cur_object_type = 5'd2;
	logic [3:0]  cur_rate_index = 4'd4;
	logic [3:0]  cur_channel_setup = 4'd2;
	logic [12:0] frame_left = '0;

	bit          item_fire = 1'b0;
	bit          result_fire = 1'b0;
	bit          send_steady = 1'b0;
	bit          recv_steady = 1'b0;
	int          send_wait = 0;
	int          recv_wait = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	aac_fr_pkg::out_item_t want;

	function automatic int draw_wait(bit steady);
		return steady ? 0 : int'($urandom_range(0, 7));
	endfunction

	// header plus payload byte for a frame start, payload byte for a word in an open frame, nothing otherwise
	task automatic predict_adts_bytes(aac_fr_pkg::in_item_t w);
		logic [12:0] n;
		logic [12:0] total;
		logic [1:0]  profile;
		logic [2:0]  ch;
		logic [7:0]  hdr [7];
		aac_fr_pkg::out_item_t r;
		if (w.frame_start) begin
			n = w.frame_bytes;
			if (n == 13'd0)
				n = 13'd1;
			if (n > aac_fr_pkg::MAX_PAYLOAD)
				n = aac_fr_pkg::MAX_PAYLOAD;
			total = n + 13'd7;
			profile = cur_object_type[1:0] - 2'd1;
			ch = cur_channel_setup[2:0];
			hdr[0] = aac_fr_pkg::SYNC_HI;
			hdr[1] = aac_fr_pkg::SYNC_LO;
			hdr[2] = {profile, cur_rate_index, 1'b0, ch[2]};
			hdr[3] = {ch[1:0], 4'b0000, total[12:11]};
			hdr[4] = total[10:3];
			hdr[5] = {total[2:0], 5'h1F};
			hdr[6] = aac_fr_pkg::HDR_TAIL;
			for (int i = 0; i < 7; i++) begin
				r.out_byte = hdr[i];
				r.is_header = 1'b1;
				r.frame_end = 1'b0;
				r.run_last = 1'b0;
				adts_bytes_due.push_back(r);
			end
			frame_left = n - 13'd1;
		end else if (frame_left != 13'd0) begin
			frame_left = frame_left - 13'd1;
		end else begin
			return;
		end
		r.out_byte = w.payload_byte;
		r.is_header = 1'b0;
		r.frame_end = (frame_left == 13'd0);
		r.run_last = 1'b1;
		adts_bytes_due.push_back(r);
	endtask

	task automatic note_mismatch(string what, aac_fr_pkg::out_item_t exp_w,
			aac_fr_pkg::out_item_t got_w);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: expected byte %02h hdr %0b end %0b last %0b,",
				" got byte %02h hdr %0b end %0b last %0b"},
				$realtime, what, exp_w.out_byte, exp_w.is_header, exp_w.frame_end,
				exp_w.run_last, got_w.out_byte, got_w.is_header, got_w.frame_end,
				got_w.run_last);
	endtask

	// handshakes, register shadow, prediction, checking and watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			item_fire = 1'b0;
			result_fire = 1'b0;
		end else begin
			item_fire = item_valid && item_ready;
			result_fire = result_valid && result_ready;
			if (cfg_we) begin
				case (cfg_index)
					aac_fr_pkg::CFG_OBJECT_TYPE:       cur_object_type = cfg_data[4:0];
					aac_fr_pkg::CFG_SAMPLE_RATE_INDEX: cur_rate_index = cfg_data[3:0];
					aac_fr_pkg::CFG_CHANNEL_SETUP:     cur_channel_setup = cfg_data[3:0];
					default: ;
				endcase
			end
			if (item_fire)
				predict_adts_bytes(item);
			if (result_fire) begin
				results_seen++;
				if (adts_bytes_due.size() == 0) begin
					note_mismatch("unexpected word", '0, result);
				end else begin
					want = adts_bytes_due.pop_front();
					if (want.out_byte !== result.out_byte
							|| want.is_header !== result.is_header
							|| want.frame_end !== result.frame_end
							|| want.run_last !== result.run_last)
						note_mismatch("wrong word", want, result);
				end
			end
			if (item_fire || result_fire) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t watchdog: no handshake for %0d cycles", $realtime,
						quiet_cycles);
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_fire) begin
			if (item_fire)
				send_wait = draw_wait(send_steady);
			if (send_wait > 0) begin
				send_wait--;
				item_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				item <= pending_words.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off once traffic is under way
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_fire)
				recv_wait = draw_wait(recv_steady);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic queue_word(logic [7:0] b, bit start, logic [12:0] len);
		aac_fr_pkg::in_item_t w;
		w.payload_byte = b;
		w.frame_start = start;
		w.frame_bytes = len;
		pending_words.push_back(w);
	endtask

	// start word declaring len_field, then nbytes-1 continuation words
	task automatic queue_frame(int len_field, int nbytes);
		queue_word(8'($urandom_range(0, 255)), 1'b1, 13'(len_field));
		for (int i = 1; i < nbytes; i++)
			queue_word(8'($urandom_range(0, 255)), 1'b0, 13'($urandom_range(0, 8191)));
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || item_valid || adts_bytes_due.size() != 0)
			@(posedge clk);
		// a dropped word may still be in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(aac_fr_pkg::cfg_idx_t idx,
			logic [aac_fr_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic random_phase(int count);
		int made;
		int pick;
		int len;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = $urandom_range(1, 6);
				queue_frame(len, len);
				made += len;
			end else if (pick < 75) begin
				queue_frame(0, 1);
				made++;
			end else if (pick < 85) begin
				// stray bytes, dropped unless a broken frame is still open
				len = $urandom_range(1, 3);
				repeat (len)
					queue_word(8'($urandom_range(0, 255)), 1'b0,
						13'($urandom_range(0, 8191)));
			end else begin
				// frame cut short by the next start
				len = $urandom_range(1, 4);
				queue_frame($urandom_range(len + 1, 8191), len);
				made += len;
			end
		end
		len = $urandom_range(1, 4);
		queue_frame(len, len);
	endtask

	task automatic run_phase(logic [4:0] ot, logic [3:0] sri, logic [3:0] ch,
			bit s_steady, bit r_steady);
		wait_idle();
		write_reg(aac_fr_pkg::CFG_OBJECT_TYPE, ot);
		write_reg(aac_fr_pkg::CFG_SAMPLE_RATE_INDEX, {1'b0, sri});
		write_reg(aac_fr_pkg::CFG_CHANNEL_SETUP, {1'b0, ch});
		@(negedge clk);
		cfg_we <= 1'b0;
		send_steady = s_steady;
		recv_steady = r_steady;
		random_phase(PHASE_WORDS);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, length extremes, drops, abandoned frames
		queue_word(8'h00, 1'b0, 13'h0000);
		queue_word(8'hFF, 1'b1, 13'd1);
		queue_word(8'h5A, 1'b1, 13'd0);
		queue_word(8'h00, 1'b1, 13'd2);
		queue_word(8'hFF, 1'b0, 13'h1FFF);
		queue_word(8'hA5, 1'b1, aac_fr_pkg::MAX_PAYLOAD);
		queue_word(8'h01, 1'b0, 13'h0000);
		queue_word(8'h80, 1'b0, 13'h0000);
		queue_word(8'h3C, 1'b1, 13'h1FFF);
		queue_word(8'hC3, 1'b0, 13'h0000);
		queue_word(8'h55, 1'b1, 13'h0AAA);
		queue_word(8'hAA, 1'b1, 13'h1555);
		queue_word(8'h7F, 1'b1, 13'd8185);
		queue_word(8'h12, 1'b1, 13'd3);
		queue_word(8'h34, 1'b0, 13'h0000);
		queue_word(8'h56, 1'b0, 13'h0000);
		queue_word(8'hFE, 1'b0, 13'h1FFF);

		run_phase(5'd0, 4'd0, 4'd0, 1'b1, 1'b0);
		run_phase(5'd31, 4'd15, 4'd15, 1'b1, 1'b1);
		run_phase(5'd1, 4'd12, 4'd7, 1'b0, 1'b0);
		run_phase(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15)), 1'b0, 1'b1);
		run_phase(5'd3, 4'd8, 4'd1, 1'b0, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		if (adts_bytes_due.size() != 0)
			$display("%0d expected words never arrived", adts_bytes_due.size());
		if (mismatches == 0 && adts_bytes_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
